// ===== hdl/gbst_pkg.sv =====
// Shared types, state codes and register indexes for the geofence breach tracker.
package gbst_pkg;

    // Slot capacity of the register map and widths of the fixed fields.
    localparam int SLOT_CAP    = 8;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int GRACE_W     = 32;
    localparam int STATES_W    = 2 * SLOT_CAP;

    // Per-slot breach state.
    typedef logic [1:0] state_t;

    localparam state_t ST_INSIDE  = 2'd0;
    localparam state_t ST_WARNING = 2'd1;
    localparam state_t ST_BREACH  = 2'd2;
    localparam state_t ST_ALERTED = 2'd3;

    // Outside fixes counted before a breach becomes an alert.
    localparam logic [COUNT_W-1:0] ALERT_COUNT = 8'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_OUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 3'd6;

    // Control that the top level hands to each slot lane.
    typedef struct packed {
        logic clear;
        logic step;
        logic in_ok;
    } lane_ctrl_t;

endpackage

// ===== hdl/geofence_breach_state_tracker.sv =====
// Top level of the geofence breach state tracker: config registers, slot lanes, output buffer.
//
// Takes one position fix per clock cycle while in_ready is high and returns one result word
// per fix, registered in the output buffer. All FENCE_SLOTS slots update side by side in their
// own lanes, each with one 32-bit subtract and compare, so the sustained rate is one fix per
// cycle while out_ready stays high; a two-word output buffer takes one more fix while out_ready
// is low, and in_ready drops only when both words are full. Any write to registers 0 to 5
// returns every slot to inside; writes to other indexes are ignored. Absent slots read as zero.
module geofence_breach_state_tracker
    import gbst_pkg::*;
#(
    parameter int FENCE_SLOTS = SLOT_CAP
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TIME_W-1:0]     fix_time,
    input  logic [SLOT_CAP-1:0]   inside_bits,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            worst_state,
    output logic [STATES_W-1:0]   slot_states
);

    logic [FENCE_SLOTS-1:0]   active_reg;
    logic [FENCE_SLOTS-1:0]   keep_out_reg;
    logic                     cfg_hit;
    logic                     in_fire;
    logic                     out_fire;
    logic [2*FENCE_SLOTS-1:0] lane_states;
    state_t                   merged_worst;
    logic [STATES_W-1:0]      merged_states;

    logic                     main_valid_reg;
    state_t                   main_worst_reg;
    logic [STATES_W-1:0]      main_states_reg;
    logic                     skid_valid_reg;
    state_t                   skid_worst_reg;
    logic [STATES_W-1:0]      skid_states_reg;

    assign cfg_hit  = cfg_we && (cfg_index < REG_COUNT);
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = main_valid_reg && out_ready;

    // Mask registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            keep_out_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ACTIVE)
            begin
                active_reg <= cfg_data[FENCE_SLOTS-1:0];
            end
            if (cfg_index == REG_KEEP_OUT)
            begin
                keep_out_reg <= cfg_data[FENCE_SLOTS-1:0];
            end
        end
    end

    // One lane per slot, each with its own grace period register.
    for (genvar s = 0; s < FENCE_SLOTS; s++)
    begin : g_slot
        localparam logic [CFG_IDX_W-1:0] GRACE_IDX = CFG_IDX_W'(REG_GRACE_BASE + s / 2);
        localparam int                   GRACE_LO  = (s % 2) * GRACE_W;

        logic [GRACE_W-1:0] grace_reg;
        lane_ctrl_t         ctrl;
        state_t             state_after;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                grace_reg <= '0;
            end
            else if (cfg_we && (cfg_index == GRACE_IDX))
            begin
                grace_reg <= cfg_data[GRACE_LO +: GRACE_W];
            end
        end

        assign ctrl.clear = cfg_hit;
        assign ctrl.step  = in_fire && active_reg[s];
        assign ctrl.in_ok = inside_bits[s] ^ keep_out_reg[s];

        gbst_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .now         (fix_time),
            .grace       (grace_reg),
            .state_after (state_after)
        );

        assign lane_states[2*s +: 2] = state_after;
    end

    gbst_merge #(
        .FENCE_SLOTS (FENCE_SLOTS)
    ) u_merge (
        .lane_states (lane_states),
        .active      (active_reg),
        .worst_state (merged_worst),
        .slot_states (merged_states)
    );

    // Output buffer: main word drives the port, skid word catches a fix during a stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire && skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire && (!main_valid_reg || out_fire))
            begin
                main_valid_reg <= 1'b1;
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output buffer.
    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
        begin
            main_worst_reg  <= skid_worst_reg;
            main_states_reg <= skid_states_reg;
        end
        else if (in_fire && (!main_valid_reg || out_fire))
        begin
            main_worst_reg  <= merged_worst;
            main_states_reg <= merged_states;
        end
        if (in_fire && main_valid_reg && !out_fire)
        begin
            skid_worst_reg  <= merged_worst;
            skid_states_reg <= merged_states;
        end
    end

    assign out_valid   = main_valid_reg;
    assign worst_state = main_worst_reg;
    assign slot_states = main_states_reg;

endmodule

// ===== hdl/gbst_lane.sv =====
// One fence slot: breach state machine with its exit stamp and outside counter.
module gbst_lane
    import gbst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctrl_t         ctrl,
    input  logic [TIME_W-1:0]  now,
    input  logic [GRACE_W-1:0] grace,
    output state_t             state_after
);

    state_t             state_reg, state_next;
    logic [TIME_W-1:0]  stamp_reg, stamp_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]  elapsed;
    logic [COUNT_W-1:0] count_inc;
    logic               grace_hit;

    // Wrapping time since the exit and the incremented outside count.
    assign elapsed   = now - stamp_reg;
    assign grace_hit = (elapsed >= grace);
    assign count_inc = count_reg + COUNT_W'(1);

    // Next state for the current word; held when the slot does not step.
    always_comb
    begin
        state_next = state_reg;
        stamp_next = stamp_reg;
        count_next = count_reg;
        if (ctrl.step)
        begin
            if (state_reg == ST_INSIDE)
            begin
                if (!ctrl.in_ok)
                begin
                    state_next = ST_WARNING;
                    stamp_next = now;
                    count_next = COUNT_W'(1);
                end
            end
            else if (ctrl.in_ok)
            begin
                state_next = ST_INSIDE;
                count_next = '0;
            end
            else
            begin
                case (state_reg)
                    ST_WARNING:
                    begin
                        count_next = count_inc;
                        if (grace_hit)
                        begin
                            state_next = ST_BREACH;
                        end
                    end
                    ST_BREACH:
                    begin
                        count_next = count_inc;
                        if (count_inc >= ALERT_COUNT)
                        begin
                            state_next = ST_ALERTED;
                        end
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
        end
    end

    assign state_after = state_next;

    // Slot registers; a clear from any configuration write to registers 0 to 5 returns the slot to inside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INSIDE;
            stamp_reg <= '0;
            count_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            state_reg <= ST_INSIDE;
            stamp_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stamp_reg <= stamp_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/gbst_merge.sv =====
// Merges the lane states into the worst active state and the packed state field.
module gbst_merge
    import gbst_pkg::*;
#(
    parameter int FENCE_SLOTS = SLOT_CAP
)
(
    input  logic [2*FENCE_SLOTS-1:0] lane_states,
    input  logic [FENCE_SLOTS-1:0]   active,
    output state_t                   worst_state,
    output logic [STATES_W-1:0]      slot_states
);

    // Maximum over active slots and packing with absent slots read as zero.
    always_comb
    begin
        worst_state = ST_INSIDE;
        slot_states = '0;
        for (int s = 0; s < FENCE_SLOTS; s++)
        begin
            slot_states[2*s +: 2] = lane_states[2*s +: 2];
            if (active[s] && (lane_states[2*s +: 2] > worst_state))
            begin
                worst_state = lane_states[2*s +: 2];
            end
        end
    end

endmodule
